[src/vast_pkg.sv]
`timescale 1ns / 1ps

package vast_pkg;

    // Default build values
    localparam int SAMPLES_PER_WINDOW_DEF = 10;
    localparam int HOLD_REARM_MS_DEF      = 2000;

    // Field widths
    localparam int ACCEL_W = 16;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = 36;
    localparam int TMR_W   = 24;
    localparam int CFG_W   = 36;
    localparam int IDX_W   = 3;
    localparam int SQ_W    = 31;    // one axis squared, up to 2^30

    // Queue depths
    localparam int MID_DEPTH = 4;
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int RES_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_SLEEP,
        PH_DETECT,
        PH_RUN,
        PH_HOLD
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_WAKE,
        EV_CONFIRM,
        EV_ABORT,
        EV_DISCARD,
        EV_DONE,
        EV_TIMEOUT,
        EV_REARM
    } event_t;

    typedef enum logic [1:0] {
        CL_IDLE,
        CL_PUMP,
        CL_SPIKE,
        CL_NONE
    } class_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ACTIVE_THR,
        REG_SPIKE_THR,
        REG_CONFIRM,
        REG_CALM,
        REG_DETECT_ABORT,
        REG_SPIKE_ONLY,
        REG_MIN_SHOT,
        REG_HOLD
    } cfg_index_t;

    // Item handed from the front to the back
    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] sq;
        logic [TIME_W-1:0] stamp;
    } sample_t;

    // One result beat
    typedef struct packed {
        phase_t            state;
        event_t            evt;
        class_t            cls;
        logic [TIME_W-1:0] shown;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0] active_thr;
        logic [SUM_W-1:0] spike_thr;
        logic [TMR_W-1:0] confirm;
        logic [TMR_W-1:0] calm;
        logic [TMR_W-1:0] detect_abort;
        logic [TMR_W-1:0] spike_only;
        logic [TMR_W-1:0] min_shot;
        logic [TMR_W-1:0] hold;
    } cfg_t;

    typedef struct packed {
        logic             en;
        cfg_index_t       index;
        logic [CFG_W-1:0] data;
    } cfg_wr_t;

endpackage

[src/vast_fifo.sv]
`timescale 1ns / 1ps

module vast_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               wr_data,
    input  logic                           pop,
    output logic [WIDTH-1:0]               rd_data,
    output logic                           empty,
    output logic                           full,
    output logic [$clog2(DEPTH + 1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(DEPTH - 1))
            res = '0;
        else
            res = ptr + 1'b1;
        return res;
    endfunction

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push_ok ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_ok) - CNT_W'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/vast_front.sv]
`timescale 1ns / 1ps

// Intake: squares the three axes, registers, then sums them.
// Admission is credit based on everything in flight plus the queue.
module vast_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  mode,
    input  logic signed [vast_pkg::ACCEL_W-1:0]   accel_x,
    input  logic signed [vast_pkg::ACCEL_W-1:0]   accel_y,
    input  logic signed [vast_pkg::ACCEL_W-1:0]   accel_z,
    input  logic [vast_pkg::TIME_W-1:0]           now_ms,
    input  logic [vast_pkg::MID_CNT_W-1:0]        q_count,
    output logic                                  q_push,
    output vast_pkg::sample_t                     q_item
);

    localparam int OCC_W = vast_pkg::MID_CNT_W + 2;

    logic signed [2*vast_pkg::ACCEL_W-1:0] prod_x, prod_y, prod_z;
    logic [OCC_W-1:0]                      occ;
    logic                                  accept;

    logic                            s1_valid_reg, s1_valid_next;
    logic                            s1_mode_reg;
    logic [vast_pkg::SQ_W-1:0]       s1_sqx_reg, s1_sqy_reg, s1_sqz_reg;
    logic [vast_pkg::TIME_W-1:0]     s1_stamp_reg;
    logic                            s2_valid_reg, s2_valid_next;
    vast_pkg::sample_t               s2_item_reg, s2_item_next;

    assign occ    = OCC_W'(q_count) + OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg);
    assign full   = (occ >= OCC_W'(vast_pkg::MID_DEPTH));
    assign accept = push && !full;

    assign prod_x = accel_x * accel_x;
    assign prod_y = accel_y * accel_y;
    assign prod_z = accel_z * accel_z;

    always_comb
    begin
        s1_valid_next      = accept;
        s2_valid_next      = s1_valid_reg;
        s2_item_next.mode  = s1_mode_reg;
        s2_item_next.stamp = s1_stamp_reg;
        // three squares of at most 2^30 each fit in 32 bits
        s2_item_next.sq    = vast_pkg::TIME_W'(s1_sqx_reg) + vast_pkg::TIME_W'(s1_sqy_reg)
                           + vast_pkg::TIME_W'(s1_sqz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg  <= mode;
        s1_sqx_reg   <= prod_x[vast_pkg::SQ_W-1:0];
        s1_sqy_reg   <= prod_y[vast_pkg::SQ_W-1:0];
        s1_sqz_reg   <= prod_z[vast_pkg::SQ_W-1:0];
        s1_stamp_reg <= now_ms;
        s2_item_reg  <= s2_item_next;
    end

    assign q_push = s2_valid_reg;
    assign q_item = s2_item_reg;

    // credits must keep the queue from overflowing
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= OCC_W'(vast_pkg::MID_DEPTH))
        else $error("front occupancy exceeds queue depth");

endmodule

[src/vast_back.sv]
`timescale 1ns / 1ps

// Window accumulator, classifier, shot FSM; one item per cycle if res_room.
module vast_back #(
    parameter int SAMPLES_PER_WINDOW = vast_pkg::SAMPLES_PER_WINDOW_DEF,
    parameter int HOLD_REARM_MS      = vast_pkg::HOLD_REARM_MS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vast_pkg::cfg_wr_t    cfg_wr,
    input  logic                 q_valid,
    input  vast_pkg::sample_t    q_item,
    output logic                 q_pop,
    input  logic                 res_room,
    output logic                 res_push,
    output vast_pkg::result_t    res_item
);

    localparam int CNT_W = $clog2(SAMPLES_PER_WINDOW + 1);
    localparam int TW    = vast_pkg::TIME_W;
    localparam int SW    = vast_pkg::SUM_W;

    vast_pkg::cfg_t    cfg_reg;
    vast_pkg::phase_t  phase_reg, phase_next;
    logic [TW-1:0]     shot_start_reg, shot_start_next;
    logic [TW-1:0]     last_motion_reg, last_motion_next;
    logic [TW-1:0]     last_pump_reg, last_pump_next;
    logic [TW-1:0]     hold_start_reg, hold_start_next;
    logic [TW-1:0]     final_time_reg, final_time_next;
    logic [SW-1:0]     win_sum_reg, win_sum_next;
    logic [CNT_W-1:0]  win_cnt_reg, win_cnt_next;
    logic [TW-1:0]     win_time_reg, win_time_next;

    logic              take;
    logic [SW-1:0]     sum_add;
    logic [CNT_W-1:0]  cnt_inc;
    logic              window_end;
    logic [TW-1:0]     now_w;
    logic              motion, pump, spike;
    vast_pkg::class_t  cls_eval;
    logic [TW-1:0]     age_start, age_motion, age_pump, age_hold, final_calc;
    vast_pkg::event_t  evt;
    vast_pkg::class_t  cls;
    logic              emit;

    assign take    = q_valid && res_room;
    assign q_pop   = take;

    assign sum_add    = win_sum_reg + SW'(q_item.sq);
    assign cnt_inc    = win_cnt_reg + 1'b1;
    assign window_end = (cnt_inc == CNT_W'(SAMPLES_PER_WINDOW));
    // window timestamp is that of its first sample
    assign now_w      = (win_cnt_reg == '0) ? q_item.stamp : win_time_reg;

    assign motion   = sum_add > cfg_reg.active_thr;
    assign pump     = motion && (sum_add <= cfg_reg.spike_thr);
    assign spike    = motion && !pump;
    assign cls_eval = spike ? vast_pkg::CL_SPIKE
                    : (pump ? vast_pkg::CL_PUMP : vast_pkg::CL_IDLE);

    // differences against the old marks; motion/pump select afterwards
    assign age_start  = now_w - shot_start_reg;
    assign age_motion = now_w - last_motion_reg;
    assign age_pump   = now_w - last_pump_reg;
    assign age_hold   = now_w - hold_start_reg;
    assign final_calc = last_pump_reg - shot_start_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        shot_start_next  = shot_start_reg;
        last_motion_next = last_motion_reg;
        last_pump_next   = last_pump_reg;
        hold_start_next  = hold_start_reg;
        final_time_next  = final_time_reg;
        win_sum_next     = win_sum_reg;
        win_cnt_next     = win_cnt_reg;
        win_time_next    = win_time_reg;
        evt              = vast_pkg::EV_NONE;
        cls              = vast_pkg::CL_NONE;
        emit             = 1'b0;

        if (take)
        begin
            if (q_item.mode)
            begin
                if (phase_reg == vast_pkg::PH_SLEEP)
                begin
                    phase_next       = vast_pkg::PH_DETECT;
                    shot_start_next  = q_item.stamp;
                    last_motion_next = q_item.stamp;
                    last_pump_next   = q_item.stamp;
                    win_sum_next     = '0;
                    win_cnt_next     = '0;
                    win_time_next    = '0;
                    evt              = vast_pkg::EV_WAKE;
                    emit             = 1'b1;
                end
            end
            else if (phase_reg != vast_pkg::PH_SLEEP)
            begin
                if (window_end)
                begin
                    win_sum_next  = '0;
                    win_cnt_next  = '0;
                    win_time_next = '0;
                    emit          = 1'b1;
                    case (phase_reg)
                        vast_pkg::PH_DETECT:
                        begin
                            cls = cls_eval;
                            if (motion)
                                last_motion_next = now_w;
                            if (pump)
                                last_pump_next = now_w;
                            if (age_start >= TW'(cfg_reg.confirm) && motion)
                            begin
                                phase_next = vast_pkg::PH_RUN;
                                evt        = vast_pkg::EV_CONFIRM;
                            end
                            else if (!motion && age_motion > TW'(cfg_reg.calm)
                                     && age_start > TW'(cfg_reg.detect_abort))
                            begin
                                phase_next = vast_pkg::PH_SLEEP;
                                evt        = vast_pkg::EV_ABORT;
                            end
                        end
                        vast_pkg::PH_RUN:
                        begin
                            cls = cls_eval;
                            if (motion)
                                last_motion_next = now_w;
                            if (pump)
                                last_pump_next = now_w;
                            // either end implies no pump this window
                            if ((!motion && age_motion > TW'(cfg_reg.calm))
                                || (spike && age_pump > TW'(cfg_reg.spike_only)))
                            begin
                                final_time_next = final_calc;
                                if (final_calc < TW'(cfg_reg.min_shot))
                                begin
                                    phase_next = vast_pkg::PH_SLEEP;
                                    evt        = vast_pkg::EV_DISCARD;
                                end
                                else
                                begin
                                    phase_next      = vast_pkg::PH_HOLD;
                                    hold_start_next = now_w;
                                    evt             = vast_pkg::EV_DONE;
                                end
                            end
                        end
                        vast_pkg::PH_HOLD:
                        begin
                            if (age_hold > TW'(cfg_reg.hold))
                            begin
                                phase_next = vast_pkg::PH_SLEEP;
                                evt        = vast_pkg::EV_TIMEOUT;
                            end
                            else if (age_hold >= TW'(HOLD_REARM_MS))
                            begin
                                cls = cls_eval;
                                if (motion)
                                begin
                                    phase_next       = vast_pkg::PH_DETECT;
                                    shot_start_next  = now_w;
                                    last_motion_next = now_w;
                                    last_pump_next   = now_w;
                                    evt              = vast_pkg::EV_REARM;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    win_sum_next = sum_add;
                    win_cnt_next = cnt_inc;
                    if (win_cnt_reg == '0)
                        win_time_next = q_item.stamp;
                end
            end
        end

        res_push       = emit;
        res_item.state = phase_next;
        res_item.evt   = evt;
        res_item.cls   = cls;
        case (phase_next)
            vast_pkg::PH_RUN:  res_item.shown = age_start;
            vast_pkg::PH_HOLD: res_item.shown = final_time_next;
            default:           res_item.shown = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= vast_pkg::PH_SLEEP;
            shot_start_reg  <= '0;
            last_motion_reg <= '0;
            last_pump_reg   <= '0;
            hold_start_reg  <= '0;
            final_time_reg  <= '0;
            win_sum_reg     <= '0;
            win_cnt_reg     <= '0;
            win_time_reg    <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            shot_start_reg  <= shot_start_next;
            last_motion_reg <= last_motion_next;
            last_pump_reg   <= last_pump_next;
            hold_start_reg  <= hold_start_next;
            final_time_reg  <= final_time_next;
            win_sum_reg     <= win_sum_next;
            win_cnt_reg     <= win_cnt_next;
            win_time_reg    <= win_time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr.en)
        begin
            case (cfg_wr.index)
                vast_pkg::REG_ACTIVE_THR:   cfg_reg.active_thr   <= cfg_wr.data;
                vast_pkg::REG_SPIKE_THR:    cfg_reg.spike_thr    <= cfg_wr.data;
                vast_pkg::REG_CONFIRM:
                    cfg_reg.confirm      <= cfg_wr.data[vast_pkg::TMR_W-1:0];
                vast_pkg::REG_CALM:
                    cfg_reg.calm         <= cfg_wr.data[vast_pkg::TMR_W-1:0];
                vast_pkg::REG_DETECT_ABORT:
                    cfg_reg.detect_abort <= cfg_wr.data[vast_pkg::TMR_W-1:0];
                vast_pkg::REG_SPIKE_ONLY:
                    cfg_reg.spike_only   <= cfg_wr.data[vast_pkg::TMR_W-1:0];
                vast_pkg::REG_MIN_SHOT:
                    cfg_reg.min_shot     <= cfg_wr.data[vast_pkg::TMR_W-1:0];
                vast_pkg::REG_HOLD:
                    cfg_reg.hold         <= cfg_wr.data[vast_pkg::TMR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sleeping machine keeps an empty window
    a_sleep_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == vast_pkg::PH_SLEEP) |-> (win_cnt_reg == '0))
        else $error("window not empty in sleep");

    // machine moves only on a consumed item
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(phase_reg))
        else $error("phase changed without an item");

    // no time shown outside running or holding
    a_shown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res_item.state == vast_pkg::PH_SLEEP
                      || res_item.state == vast_pkg::PH_DETECT))
        |-> (res_item.shown == '0))
        else $error("nonzero shown time in sleep or detecting");

endmodule

[src/vibration_activity_shot_timer.sv]
`timescale 1ns / 1ps

// Vibration shot timer. Push accelerometer samples (mode 0) or wake events
// (mode 1) while full is low; one item is taken per clock, back to back.
// Each sample's x*x+y*y+z*z is summed over windows of SAMPLES_PER_WINDOW
// samples; at every window end (and on a wake taken in sleep) one result
// beat is queued with the machine state, the event, the window class and
// the time shown. Wakes outside sleep and samples in sleep give no beat.
// An item taken is squared into the first stage, summed into the second
// stage and written into the intake queue; the state machine consumes it
// from that queue and writes its result beat into the result queue, whose
// head is on the result ports. The machine takes one item per cycle while
// the result queue has room; its window add, threshold compare and update
// are combinational. full rises once four items sit between the input and
// the machine (both stages plus the intake queue); the machine stalls while
// the two-entry result queue is full, so a receiver that holds off fills
// both queues and then stalls the input. Registers are written over
// wr_en/wr_index/wr_data only while idle; the user must keep to this, as
// the block itself does not enforce it.
module vibration_activity_shot_timer #(
    parameter int SAMPLES_PER_WINDOW = vast_pkg::SAMPLES_PER_WINDOW_DEF,
    parameter int HOLD_REARM_MS      = vast_pkg::HOLD_REARM_MS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input queue side
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 mode,
    input  logic signed [vast_pkg::ACCEL_W-1:0]  accel_x,
    input  logic signed [vast_pkg::ACCEL_W-1:0]  accel_y,
    input  logic signed [vast_pkg::ACCEL_W-1:0]  accel_z,
    input  logic [vast_pkg::TIME_W-1:0]          now_ms,
    // result queue side
    output logic                                 empty,
    input  logic                                 pop,
    output logic [1:0]                           machine_state,
    output logic [2:0]                           event_res,
    output logic [1:0]                           window_class,
    output logic [vast_pkg::TIME_W-1:0]          shown_ms,
    // register write port
    input  logic                                 wr_en,
    input  logic [vast_pkg::IDX_W-1:0]           wr_index,
    input  logic [vast_pkg::CFG_W-1:0]           wr_data
);

    localparam int MID_W = $bits(vast_pkg::sample_t);
    localparam int RES_W = $bits(vast_pkg::result_t);

    // front -> intake queue
    logic                            mid_push;
    vast_pkg::sample_t               mid_wr;
    logic [MID_W-1:0]                mid_rd;
    vast_pkg::sample_t               mid_item;
    logic                            mid_empty;
    logic                            mid_pop;
    logic [vast_pkg::MID_CNT_W-1:0]  mid_count;

    // back -> result queue
    logic                            res_push;
    vast_pkg::result_t               res_wr;
    logic                            res_full;
    logic [RES_W-1:0]                res_rd;
    vast_pkg::result_t               res_out;

    vast_pkg::cfg_wr_t               cfg_wr;

    assign cfg_wr.en    = wr_en;
    assign cfg_wr.index = vast_pkg::cfg_index_t'(wr_index);
    assign cfg_wr.data  = wr_data;

    vast_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .mode    (mode),
        .accel_x (accel_x),
        .accel_y (accel_y),
        .accel_z (accel_z),
        .now_ms  (now_ms),
        .q_count (mid_count),
        .q_push  (mid_push),
        .q_item  (mid_wr)
    );

    // intake queue; the front's credit check keeps it from overflowing
    vast_fifo #(
        .WIDTH (MID_W),
        .DEPTH (vast_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (mid_wr),
        .pop     (mid_pop),
        .rd_data (mid_rd),
        .empty   (mid_empty),
        .full    (),
        .count   (mid_count)
    );

    assign mid_item = mid_rd;

    vast_back #(
        .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW),
        .HOLD_REARM_MS      (HOLD_REARM_MS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .q_valid  (!mid_empty),
        .q_item   (mid_item),
        .q_pop    (mid_pop),
        .res_room (!res_full),
        .res_push (res_push),
        .res_item (res_wr)
    );

    // result queue doubles as the output register
    vast_fifo #(
        .WIDTH (RES_W),
        .DEPTH (vast_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wr),
        .pop     (pop),
        .rd_data (res_rd),
        .empty   (empty),
        .full    (res_full),
        .count   ()
    );

    assign res_out       = res_rd;
    assign machine_state = res_out.state;
    assign event_res     = res_out.evt;
    assign window_class  = res_out.cls;
    assign shown_ms      = res_out.shown;

endmodule
